// ===== rtl/core/hg3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hg3_pkg;

  localparam int MaxWidth    = 2048;
  localparam int MaxHeight   = 2048;
  localparam int MaxChannels = 4;
  localparam int MinSize     = 3;
  localparam int StoreDepth  = 8192;

  localparam int AddrW  = $clog2(StoreDepth);
  localparam int ChW    = $clog2(MaxChannels);
  localparam int RowW   = 11;
  localparam int CfgW   = 12;
  localparam int ChanW  = 3;
  localparam int LenW   = AddrW + 1;
  localparam int PixW   = 8;
  localparam int EntryW = 2 * PixW;

  localparam logic [PixW-1:0] BorderValue = '0;

  // exact floor(col / 3) for 13-bit col: multiply by reciprocal, one correction
  localparam int Recip3W = 14;
  localparam logic [Recip3W-1:0] Recip3 = 14'd5462;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgW-1:0]  width;
    logic [CfgW-1:0]  height;
    logic [ChanW-1:0] chans;
    logic [LenW-1:0]  row_len;
  } geom_t;

  typedef struct packed {
    logic [AddrW-1:0] col;
    logic [AddrW-1:0] x;
    logic [ChW-1:0]   ch;
    logic [RowW-1:0]  row;
  } pos_t;

  typedef struct packed {
    pos_t            pos;
    logic [PixW-1:0] pix;
  } stage_t;

endpackage
`default_nettype wire

// ===== rtl/core/hg3_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hg3_line_store (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [hg3_pkg::AddrW-1:0]  waddr_i,
  input  wire logic [hg3_pkg::EntryW-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [hg3_pkg::AddrW-1:0]  raddr_i,
  output logic      [hg3_pkg::EntryW-1:0] rdata_o
);

  // bits 7:0 row above, bits 15:8 two rows above
  logic [hg3_pkg::EntryW-1:0] mem [hg3_pkg::StoreDepth];
  logic [hg3_pkg::EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/hg3_position.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hg3_position (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          frame_start_i,
  input  wire hg3_pkg::geom_t geom_i,
  output hg3_pkg::pos_t      pos_o
);

  logic [hg3_pkg::AddrW-1:0] col_q, col_d, col_cur;
  logic [hg3_pkg::RowW-1:0]  row_q, row_d, row_cur;

  logic [hg3_pkg::AddrW+hg3_pkg::Recip3W-1:0] prod;
  logic [hg3_pkg::AddrW-1:0] q3, q3_fix;
  logic [hg3_pkg::AddrW:0]   r3;
  logic [hg3_pkg::AddrW-1:0] x;
  logic [hg3_pkg::ChW-1:0]   ch;

  assign col_cur = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;

  assign prod = (hg3_pkg::AddrW+hg3_pkg::Recip3W)'(col_cur) *
                (hg3_pkg::AddrW+hg3_pkg::Recip3W)'(hg3_pkg::Recip3);
  assign q3   = prod[hg3_pkg::AddrW+hg3_pkg::Recip3W-1:hg3_pkg::Recip3W];
  assign r3   = {1'b0, col_cur} - ({1'b0, q3} + {q3, 1'b0});

  always_comb begin
    q3_fix = q3;
    x      = col_cur;
    ch     = '0;
    case (geom_i.chans)
      3'd2: begin
        x  = {1'b0, col_cur[hg3_pkg::AddrW-1:1]};
        ch = {1'b0, col_cur[0]};
      end
      3'd3: begin
        if (r3 >= 14'd3) begin
          q3_fix = q3 + 13'd1;
          ch     = 2'(r3 - 14'd3);
        end else begin
          ch = 2'(r3);
        end
        x = q3_fix;
      end
      3'd4: begin
        x  = {2'b00, col_cur[hg3_pkg::AddrW-1:2]};
        ch = col_cur[1:0];
      end
      default: begin
        x  = col_cur;
        ch = '0;
      end
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if ({1'b0, col_cur} + 14'd1 >= geom_i.row_len) begin
        col_d = '0;
        if ({1'b0, row_cur} + 12'd1 >= geom_i.height) begin
          row_d = '0;
        end else begin
          row_d = row_cur + 11'd1;
        end
      end else begin
        col_d = col_cur + 13'd1;
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.col = col_cur;
  assign pos_o.x   = x;
  assign pos_o.ch  = ch;
  assign pos_o.row = row_cur;

endmodule
`default_nettype wire

// ===== rtl/core/hg3_kernel.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hg3_kernel (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire hg3_pkg::stage_t            stage_i,
  input  wire logic [hg3_pkg::EntryW-1:0] entry_i,
  input  wire hg3_pkg::geom_t             geom_i,
  output logic      [hg3_pkg::PixW-1:0]   value_o,
  output logic                            frame_start_o,
  output logic      [hg3_pkg::EntryW-1:0] store_wdata_o
);

  // per channel: newest pixel column and the one before, three rows each
  logic [hg3_pkg::PixW-1:0] new_q [hg3_pkg::MaxChannels][3];
  logic [hg3_pkg::PixW-1:0] old_q [hg3_pkg::MaxChannels][3];

  logic [hg3_pkg::PixW-1:0] above1, above2;
  logic [9:0]               right_sum, left_sum;
  logic signed [10:0]       diff;
  logic                     inside_img;

  assign above1 = entry_i[hg3_pkg::PixW-1:0];
  assign above2 = entry_i[hg3_pkg::EntryW-1:hg3_pkg::PixW];

  assign right_sum = 10'(stage_i.pix) + 10'(above1) + 10'(above2);
  assign left_sum  = 10'(old_q[stage_i.pos.ch][0]) + 10'(old_q[stage_i.pos.ch][1]) +
                     10'(old_q[stage_i.pos.ch][2]);
  assign diff      = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});

  assign inside_img = (stage_i.pos.row >= 11'd2) &&
                      ({1'b0, stage_i.pos.row} < geom_i.height) &&
                      (stage_i.pos.x >= 13'd2) &&
                      (stage_i.pos.x < {1'b0, geom_i.width});

  always_comb begin
    value_o = hg3_pkg::BorderValue;
    if (inside_img) begin
      if (diff < 11'sd0) begin
        value_o = 8'd0;
      end else if (diff > 11'sd255) begin
        value_o = 8'd255;
      end else begin
        value_o = diff[7:0];
      end
    end
  end

  assign frame_start_o = (stage_i.pos.row == 11'd1) &&
                         (stage_i.pos.col == 13'(geom_i.chans));

  assign store_wdata_o = {above1, stage_i.pix};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < hg3_pkg::MaxChannels; c++) begin
        for (int r = 0; r < 3; r++) begin
          new_q[c][r] <= '0;
          old_q[c][r] <= '0;
        end
      end
    end else if (fire_i) begin
      for (int r = 0; r < 3; r++) begin
        old_q[stage_i.pos.ch][r] <= new_q[stage_i.pos.ch][r];
      end
      new_q[stage_i.pos.ch][0] <= stage_i.pix;
      new_q[stage_i.pos.ch][1] <= above1;
      new_q[stage_i.pos.ch][2] <= above2;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/horizontal_gradient_3x3_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted input word passes through the input register, then the result
// register, before its result word is valid.
// Throughput: one word per cycle while the output side takes words; each word does
// one line store read at accept and one write as it leaves the input register,
// with write-to-read forwarding on the same address.
// Reset (async, active low): counters, window and handshake state clear, config
// returns to 512 x 512 x 3. The line store is not cleared.
module horizontal_gradient_3x3_filter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,   // [7:0] pixel_in
  input  wire logic                       s_axis_tuser,   // [0] frame_start
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [7:0]                 m_axis_tdata,   // [7:0] out_value
  output logic                            m_axis_tuser,   // [0] out_frame_start
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [hg3_pkg::CfgW-1:0]   cfg_data_i
);

  logic [hg3_pkg::CfgW-1:0]  width_q, height_q;
  logic [hg3_pkg::ChanW-1:0] chans_q;
  hg3_pkg::geom_t            geom;

  logic            in_accept, s1_fire;
  logic            s1_valid_q, out_valid_q;
  hg3_pkg::stage_t s1_q;
  hg3_pkg::pos_t   pos;

  logic [hg3_pkg::EntryW-1:0] rdata, entry, store_wdata, fwd_data_q;
  logic                       fwd_q;
  logic [hg3_pkg::PixW-1:0]   value;
  logic                       frame_start;
  logic [hg3_pkg::PixW-1:0]   out_value_q;
  logic                       out_fs_q;

  // effective geometry, saturated into the supported ranges
  always_comb begin
    geom.width = width_q;
    if (width_q < hg3_pkg::CfgW'(hg3_pkg::MinSize)) begin
      geom.width = hg3_pkg::CfgW'(hg3_pkg::MinSize);
    end else if (width_q > hg3_pkg::CfgW'(hg3_pkg::MaxWidth)) begin
      geom.width = hg3_pkg::CfgW'(hg3_pkg::MaxWidth);
    end
    geom.height = height_q;
    if (height_q < hg3_pkg::CfgW'(hg3_pkg::MinSize)) begin
      geom.height = hg3_pkg::CfgW'(hg3_pkg::MinSize);
    end else if (height_q > hg3_pkg::CfgW'(hg3_pkg::MaxHeight)) begin
      geom.height = hg3_pkg::CfgW'(hg3_pkg::MaxHeight);
    end
    geom.chans = chans_q;
    if (chans_q == '0) begin
      geom.chans = hg3_pkg::ChanW'(1);
    end else if (chans_q > hg3_pkg::ChanW'(hg3_pkg::MaxChannels)) begin
      geom.chans = hg3_pkg::ChanW'(hg3_pkg::MaxChannels);
    end
    geom.row_len = hg3_pkg::LenW'(geom.width) * hg3_pkg::LenW'(geom.chans);
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd512;
      height_q <= 12'd512;
      chans_q  <= 3'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (hg3_pkg::cfg_reg_e'(cfg_index_i))
        hg3_pkg::REG_WIDTH:    width_q  <= cfg_data_i;
        hg3_pkg::REG_HEIGHT:   height_q <= cfg_data_i;
        hg3_pkg::REG_CHANNELS: chans_q  <= cfg_data_i[hg3_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  hg3_position u_position (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .frame_start_i(s_axis_tuser),
    .geom_i       (geom),
    .pos_o        (pos)
  );

  hg3_line_store u_line_store (
    .clk_i  (clk_i),
    .we_i   (s1_fire),
    .waddr_i(s1_q.pos.col),
    .wdata_i(store_wdata),
    .re_i   (in_accept),
    .raddr_i(pos.col),
    .rdata_o(rdata)
  );

  // the read issued at accept misses a write to the same entry in that cycle
  assign entry = fwd_q ? fwd_data_q : rdata;

  hg3_kernel u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .stage_i      (s1_q),
    .entry_i      (entry),
    .geom_i       (geom),
    .value_o      (value),
    .frame_start_o(frame_start),
    .store_wdata_o(store_wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire && (s1_q.pos.col == pos.col);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.pos   <= pos;
      s1_q.pix   <= s_axis_tdata;
      fwd_data_q <= store_wdata;
    end
    if (s1_fire) begin
      out_value_q <= value;
      out_fs_q    <= frame_start;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_fs_q;

endmodule
`default_nettype wire
